@@ rtl/wcc_pkg.sv @@
`timescale 1ns / 1ps
package wcc_pkg;

  localparam int MAX_THREADS = 32;
  localparam int TW          = $clog2(MAX_THREADS + 1);   // thread count width
  localparam int IW          = $clog2(MAX_THREADS);       // line table index width
  localparam int AW          = 64;                        // address width
  localparam int LW          = 13;                        // line size width
  localparam int CW          = 32;                        // counter width
  localparam int CFG_IW      = 8;
  localparam int IN_DW       = 96;
  localparam int OUT_DW      = 136;

  localparam logic [CFG_IW-1:0] CFG_THREADS = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] CFG_LINE    = CFG_IW'(1);

  // one classified warp access waiting for the back end
  typedef struct packed {
    logic [AW-1:0] base;
    logic [AW-1:0] stride;
    logic [TW-1:0] threads;
    logic [LW-1:0] divisor;
  } wcc_job_t;

endpackage

@@ rtl/warp_coalescing_counter_top.sv @@
`timescale 1ns / 1ps
// per thread: a bit-serial divide of the address by the line size, then a search
//   of the line table over the lines found so far
// the back end takes one warp at a time; the bit-serial line divider and the line
//   table search, one entry at a time through a search and a compare state, set the pace
// a two-entry queue takes further warps while one is worked on and a result waits
// reset (rst_n low, synchronous): counters zero, 32 threads, 128-byte lines, queue empty
module warp_coalescing_counter_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [wcc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [wcc_pkg::LW-1:0]     cfg_data,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [wcc_pkg::IN_DW-1:0]  in_tdata,   // base_address[63:0], stride[95:64]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // transactions[5:0], coalesced[6], warp_count[38:7], transaction_count[70:39],
  // coalesced_count[102:71], uncoalesced_count[134:103], zero[135]
  output logic [wcc_pkg::OUT_DW-1:0] out_tdata
);
  import wcc_pkg::*;

  wcc_job_t push_job, pop_job;
  logic     push, full, pop, qvalid;

  wcc_front u_front (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata,
    .q_push(push), .q_job(push_job), .q_full(full)
  );

  wcc_fifo u_fifo (
    .clk, .rst_n, .push, .wdata(push_job), .full,
    .pop, .rdata(pop_job), .valid(qvalid)
  );

  wcc_back u_back (
    .clk, .rst_n, .q_valid(qvalid), .q_pop(pop), .q_job(pop_job),
    .out_tvalid, .out_tready, .out_tdata
  );

endmodule

@@ rtl/wcc_front.sv @@
`timescale 1ns / 1ps
module wcc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [wcc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [wcc_pkg::LW-1:0]     cfg_data,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [wcc_pkg::IN_DW-1:0]  in_tdata,
  output logic                       q_push,
  output wcc_pkg::wcc_job_t          q_job,
  input  logic                       q_full
);
  import wcc_pkg::*;

  logic [TW-1:0] threads_r;
  logic [LW-1:0] line_r;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threads_r <= TW'(MAX_THREADS);
      line_r    <= LW'(128);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_THREADS) threads_r <= cfg_data[TW-1:0];
      else if (cfg_index == CFG_LINE) line_r <= cfg_data;
    end
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // classify: clamp thread count, guard zero line size, sign extend stride
  always_comb begin
    q_job.base   = in_tdata[63:0];
    q_job.stride = {{32{in_tdata[95]}}, in_tdata[95:64]};
    if (threads_r == '0) q_job.threads = TW'(1);
    else if (threads_r > TW'(MAX_THREADS)) q_job.threads = TW'(MAX_THREADS);
    else q_job.threads = threads_r;
    q_job.divisor = (line_r == '0) ? LW'(1) : line_r;
  end

endmodule

@@ rtl/wcc_fifo.sv @@
`timescale 1ns / 1ps
module wcc_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wcc_pkg::wcc_job_t wdata,
  output logic              full,
  input  logic              pop,
  output wcc_pkg::wcc_job_t rdata,
  output logic              valid
);
  import wcc_pkg::*;

  wcc_job_t   ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign rdata = ent_r[rp_r];

  // two-entry queue storage
  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= wdata;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/wcc_back.sv @@
`timescale 1ns / 1ps
module wcc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  output logic                       q_pop,
  input  wcc_pkg::wcc_job_t          q_job,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [wcc_pkg::OUT_DW-1:0] out_tdata
);
  import wcc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_SRCH, S_CMP, S_NEXT, S_DONE} state_t;

  state_t        state_r;
  logic [AW-1:0] addr_r, stride_r, quo_r;
  logic [LW-1:0] div_r, rem_r;
  logic [5:0]    bit_r;
  logic [TW-1:0] n_r, i_r, cnt_r, k_r;
  logic [AW-1:0] line_mem [MAX_THREADS];
  logic [AW-1:0] rdata_r;
  logic          out_valid_r;
  logic [TW-1:0] res_tr_r;
  logic          res_coal_r;
  logic [CW-1:0] warps_r, trans_r, coal_r, uncoal_r;
  logic [LW:0]   trial;
  logic          qbit;

  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, uncoal_r, coal_r, trans_r, warps_r, res_coal_r, res_tr_r};

  // restoring divider step, one quotient bit a cycle
  assign trial = {rem_r, quo_r[AW-1]};
  assign qbit  = (trial >= {1'b0, div_r});

  // line table, registered read
  always_ff @(posedge clk) begin
    rdata_r <= line_mem[k_r[IW-1:0]];
    if (state_r == S_SRCH && k_r == cnt_r) line_mem[cnt_r[IW-1:0]] <= quo_r;
  end

  // sequencer: per thread divide, search the line table, then report
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      warps_r     <= '0;
      trans_r     <= '0;
      coal_r      <= '0;
      uncoal_r    <= '0;
      i_r         <= '0;
      cnt_r       <= '0;
      k_r         <= '0;
      bit_r       <= '0;
    end else begin
      // result beat taken; the done state refills the register itself
      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            addr_r   <= q_job.base;
            quo_r    <= q_job.base;
            stride_r <= q_job.stride;
            n_r      <= q_job.threads;
            div_r    <= q_job.divisor;
            rem_r    <= '0;
            bit_r    <= '0;
            i_r      <= '0;
            cnt_r    <= '0;
            state_r  <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= qbit ? LW'(trial - {1'b0, div_r}) : trial[LW-1:0];
          quo_r <= {quo_r[AW-2:0], qbit};
          bit_r <= bit_r + 6'd1;
          if (bit_r == 6'd63) begin
            k_r     <= '0;
            state_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (k_r == cnt_r) begin
            cnt_r   <= cnt_r + TW'(1);
            state_r <= S_NEXT;
          end else begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (rdata_r == quo_r) state_r <= S_NEXT;
          else begin
            k_r     <= k_r + TW'(1);
            state_r <= S_SRCH;
          end
        end
        S_NEXT: begin
          if (i_r + TW'(1) == n_r) state_r <= S_DONE;
          else begin
            i_r     <= i_r + TW'(1);
            addr_r  <= addr_r + stride_r;
            quo_r   <= addr_r + stride_r;
            rem_r   <= '0;
            bit_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            res_tr_r    <= cnt_r;
            res_coal_r  <= (cnt_r == TW'(1));
            warps_r     <= warps_r + CW'(1);
            trans_r     <= trans_r + CW'(cnt_r);
            if (cnt_r == TW'(1)) coal_r <= coal_r + CW'(1);
            else uncoal_r <= uncoal_r + CW'(1);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= TW'(MAX_THREADS)) else $error("line count above thread limit");
  a_done_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |-> (cnt_r >= TW'(1) && cnt_r <= n_r))
    else $error("bad line count at end of warp");
  a_thread_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_DONE) |-> (i_r < n_r && div_r != '0))
    else $error("thread index or divisor out of range");
  a_search_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> k_r < cnt_r) else $error("search past table fill");

endmodule
